[src/lrs_pkg.sv]
// Shared types and constants for the life row stepper.
// Register indexes, reset values and the edge-bit pair; no dependencies.
package lrs_pkg;

  localparam int CFG_INDEX_W    = 1;
  localparam int CFG_DATA_W     = 16;
  localparam int ACTIVE_WIDTH_W = 7;
  localparam int ROW_COUNT_W    = 16;
  localparam int ROW_INDEX_W    = 16;
  localparam int QUEUE_DEPTH    = 4;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ACTIVE_WIDTH = 1'b0,
    REG_ROW_COUNT    = 1'b1
  } cfg_reg_t;

  localparam logic [ACTIVE_WIDTH_W-1:0] ACTIVE_WIDTH_RST = 7'd64;
  localparam logic [ROW_COUNT_W-1:0]    ROW_COUNT_RST    = 16'd64;
  localparam logic [ROW_COUNT_W-1:0]    MIN_ROW_COUNT    = 16'd3;

  // Cells just outside a row: left of column 0 and right of the last column.
  typedef struct packed {
    logic right;
    logic left;
  } edge_pair_t;

endpackage

[src/lrs_cell.sv]
// One lane of the row unit: the B3/S23 rule for a single cell.
// Takes a 3x3 window (bit 0 left, bit 1 center, bit 2 right); no dependencies.
module lrs_cell (
  input  logic [2:0] up_win,
  input  logic [2:0] mid_win,
  input  logic [2:0] dn_win,
  input  logic       active,
  output logic       next_cell
);

  logic [3:0] nbr_count;

  assign nbr_count = 4'(up_win[0]) + 4'(up_win[1]) + 4'(up_win[2]) +
                     4'(mid_win[0]) + 4'(mid_win[2]) +
                     4'(dn_win[0]) + 4'(dn_win[1]) + 4'(dn_win[2]);

  // Born on three, survive on two or three; columns past the width stay dead.
  assign next_cell = active &&
                     ((nbr_count == 4'd3) || (mid_win[1] && (nbr_count == 4'd2)));

endmodule

[src/lrs_row.sv]
// Row unit: one lrs_cell lane per column plus the merge of the new edge cells.
// Depends on lrs_pkg (edge_pair_t) and lrs_cell.
module lrs_row #(
  parameter int ROW_WIDTH = 64,
  localparam int WB = $clog2(ROW_WIDTH + 1),
  localparam int IB = $clog2(ROW_WIDTH)
) (
  input  logic [ROW_WIDTH-1:0] up_row,
  input  lrs_pkg::edge_pair_t  up_edge,
  input  logic [ROW_WIDTH-1:0] mid_row,
  input  lrs_pkg::edge_pair_t  mid_edge,
  input  logic [ROW_WIDTH-1:0] dn_row,
  input  lrs_pkg::edge_pair_t  dn_edge,
  input  logic [WB-1:0]        width,
  output logic [ROW_WIDTH-1:0] res_row,
  output lrs_pkg::edge_pair_t  res_edge
);

  logic [IB-1:0] last_col;

  for (genvar c = 0; c < ROW_WIDTH; c++) begin : g_lane
    logic [2:0] up_w;
    logic [2:0] mid_w;
    logic [2:0] dn_w;
    logic       act;
    logic       at_last;

    assign act     = width > WB'(c);
    assign at_last = width == WB'(c + 1);

    if (c == 0) begin : g_left_edge
      assign up_w[0]  = up_edge.left;
      assign mid_w[0] = mid_edge.left;
      assign dn_w[0]  = dn_edge.left;
    end else begin : g_left_inner
      assign up_w[0]  = up_row[c-1];
      assign mid_w[0] = mid_row[c-1];
      assign dn_w[0]  = dn_row[c-1];
    end

    assign up_w[1]  = up_row[c];
    assign mid_w[1] = mid_row[c];
    assign dn_w[1]  = dn_row[c];

    if (c == ROW_WIDTH - 1) begin : g_right_edge
      assign up_w[2]  = up_edge.right;
      assign mid_w[2] = mid_edge.right;
      assign dn_w[2]  = dn_edge.right;
    end else begin : g_right_inner
      assign up_w[2]  = at_last ? up_edge.right  : up_row[c+1];
      assign mid_w[2] = at_last ? mid_edge.right : mid_row[c+1];
      assign dn_w[2]  = at_last ? dn_edge.right  : dn_row[c+1];
    end

    lrs_cell u_cell (
      .up_win    (up_w),
      .mid_win   (mid_w),
      .dn_win    (dn_w),
      .active    (act),
      .next_cell (res_row[c])
    );
  end

  // Width is at least one here, so the last column index never underflows.
  assign last_col       = IB'(width - WB'(1));
  assign res_edge.left  = res_row[0];
  assign res_edge.right = res_row[last_col];

endmodule

[src/lrs_queue.sv]
// Small result queue: takes up to two items per cycle while it has room for two, hands out one.
// Depends on lrs_pkg (QUEUE_DEPTH, a power of two).
module lrs_queue #(
  parameter int DATA_W = 84
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_a,
  input  logic [DATA_W-1:0] data_a,
  input  logic              push_b,
  input  logic [DATA_W-1:0] data_b,
  output logic              room_for_two,
  output logic              head_valid,
  output logic [DATA_W-1:0] head_data,
  input  logic              pop
);

  localparam int DEPTH = lrs_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] slot_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [PTR_W-1:0]  wr_ptr_b;
  logic              do_pop;

  assign wr_ptr_b     = wr_ptr_r + PTR_W'(1);
  assign do_pop       = pop && (count_r != '0);
  assign room_for_two = count_r <= CNT_W'(DEPTH - 2);
  assign head_valid   = count_r != '0;
  assign head_data    = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PTR_W'(push_a) + PTR_W'(push_b);
    rd_ptr_nxt = rd_ptr_r + PTR_W'(do_pop);
    count_nxt  = count_r + CNT_W'(push_a) + CNT_W'(push_b) - CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_a) begin
      slot_r[wr_ptr_r] <= data_a;
    end
    if (push_b) begin
      slot_r[wr_ptr_b] <= data_b;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) count_r <= CNT_W'(DEPTH))
    else $error("lrs_queue: count exceeds depth");

  assert property (@(posedge clk) disable iff (!rst_n) push_b |-> push_a)
    else $error("lrs_queue: second push without first");

  assert property (@(posedge clk) disable iff (!rst_n)
                   (push_a || push_b) |-> room_for_two)
    else $error("lrs_queue: push without room for two");

endmodule

[src/life_row_stepper.sv]
// Top level of the life row stepper: one Life generation over a wrapping strip.
// Depends on lrs_pkg, lrs_row (with lrs_cell lanes) and lrs_queue.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-----------------------------------------
//  in_     | in        | in_valid / in_ready | in_row_cells, in_left_in, in_right_in
//  out_    | out       | out_valid/out_ready | out_next_row, out_row_index, out_left_out,
//          |           |                     | out_right_out, out_last
//  cfg_    | in        | cfg_we (no wait)    | cfg_index, cfg_wdata
//
// One item per cycle: all columns of a row are computed at once by ROW_WIDTH cell
// lanes, so an item is taken in the cycle it is offered while in_ready is high.
// Results are registered into a four-entry queue and show on out_ from its head.
// in_ready is low only while that queue holds more than two results (a final row
// pushes two); a stalled out_ side fills the queue and then holds the input.
// Reset (rst_n low at a clock edge) empties the queue, drops a pending row 0 and
// starts a new generation; no clearing pass is needed.
module life_row_stepper #(
  parameter int ROW_WIDTH      = 64,
  parameter int ROW_INDEX_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,

  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [ROW_WIDTH-1:0]                in_row_cells,
  input  logic                                in_left_in,
  input  logic                                in_right_in,

  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [ROW_WIDTH-1:0]                out_next_row,
  output logic [lrs_pkg::ROW_INDEX_W-1:0]     out_row_index,
  output logic                                out_left_out,
  output logic                                out_right_out,
  output logic                                out_last,

  input  logic                                cfg_we,
  input  logic [lrs_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [lrs_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  localparam int WB     = $clog2(ROW_WIDTH + 1);
  localparam int AW_W   = lrs_pkg::ACTIVE_WIDTH_W;
  localparam int RC_W   = lrs_pkg::ROW_COUNT_W;
  localparam int IDX_W  = (ROW_INDEX_BITS < lrs_pkg::ROW_INDEX_W) ?
                          ROW_INDEX_BITS : lrs_pkg::ROW_INDEX_W;
  localparam int DATA_W = ROW_WIDTH + IDX_W + 3;

  // Configuration registers.
  logic [AW_W-1:0] active_width_r;
  logic [RC_W-1:0] row_count_r;

  // Line buffers: the two latest rows and the first two rows of the generation.
  logic [ROW_WIDTH-1:0] older_row_r, middle_row_r, first_row_r, second_row_r;
  lrs_pkg::edge_pair_t  older_edge_r, middle_edge_r, first_edge_r, second_edge_r;
  logic [RC_W-1:0]      rows_seen_r, rows_seen_nxt;

  // Row 0 result, computed on the final row and sent ahead of the next item's.
  logic                 held_valid_r;
  logic [ROW_WIDTH-1:0] held_row_r;
  lrs_pkg::edge_pair_t  held_edge_r;

  logic                 in_fire;
  logic [WB-1:0]        width_eff;
  logic [RC_W-1:0]      row_count_eff;
  logic [ROW_WIDTH-1:0] cur_row;
  lrs_pkg::edge_pair_t  cur_edge;
  logic                 final_row;
  logic                 mid_v;

  logic [ROW_WIDTH-1:0] mid_res, fin_res, wrap_res;
  lrs_pkg::edge_pair_t  mid_edge_res, fin_edge_res, wrap_edge_res;

  logic [DATA_W-1:0]    held_entry, mid_entry, fin_entry;
  logic                 push_a, push_b;
  logic [DATA_W-1:0]    data_a;
  logic                 room_for_two;
  logic [DATA_W-1:0]    head_data;

  assign in_ready = room_for_two;
  assign in_fire  = in_valid && in_ready;

  // Clamp the width to 1..ROW_WIDTH and the row count to at least three.
  always_comb begin
    if (active_width_r == '0) begin
      width_eff = WB'(1);
    end else if (active_width_r > AW_W'(ROW_WIDTH)) begin
      width_eff = WB'(ROW_WIDTH);
    end else begin
      width_eff = WB'(active_width_r);
    end
    row_count_eff = (row_count_r < lrs_pkg::MIN_ROW_COUNT) ?
                    lrs_pkg::MIN_ROW_COUNT : row_count_r;
  end

  // Drop cells at or past the active width.
  always_comb begin
    for (int c = 0; c < ROW_WIDTH; c++) begin
      cur_row[c] = in_row_cells[c] && (width_eff > WB'(c));
    end
    cur_edge.left  = in_left_in;
    cur_edge.right = in_right_in;
  end

  assign final_row = ({1'b0, rows_seen_r} + (RC_W + 1)'(1)) >= {1'b0, row_count_eff};
  assign mid_v     = rows_seen_r >= RC_W'(2);

  // Row k-1 from the two buffered rows and the incoming one.
  lrs_row #(.ROW_WIDTH(ROW_WIDTH)) u_row_mid (
    .up_row   (older_row_r),
    .up_edge  (older_edge_r),
    .mid_row  (middle_row_r),
    .mid_edge (middle_edge_r),
    .dn_row   (cur_row),
    .dn_edge  (cur_edge),
    .width    (width_eff),
    .res_row  (mid_res),
    .res_edge (mid_edge_res)
  );

  // Last row: wraps down onto row 0.
  lrs_row #(.ROW_WIDTH(ROW_WIDTH)) u_row_fin (
    .up_row   (middle_row_r),
    .up_edge  (middle_edge_r),
    .mid_row  (cur_row),
    .mid_edge (cur_edge),
    .dn_row   (first_row_r),
    .dn_edge  (first_edge_r),
    .width    (width_eff),
    .res_row  (fin_res),
    .res_edge (fin_edge_res)
  );

  // Row 0: wraps up onto the last row.
  lrs_row #(.ROW_WIDTH(ROW_WIDTH)) u_row_wrap (
    .up_row   (cur_row),
    .up_edge  (cur_edge),
    .mid_row  (first_row_r),
    .mid_edge (first_edge_r),
    .dn_row   (second_row_r),
    .dn_edge  (second_edge_r),
    .width    (width_eff),
    .res_row  (wrap_res),
    .res_edge (wrap_edge_res)
  );

  // Queue entry: row, index, right edge, left edge, last flag.
  assign held_entry = {held_row_r, IDX_W'(0), held_edge_r, 1'b1};
  assign mid_entry  = {mid_res, IDX_W'(rows_seen_r - RC_W'(1)), mid_edge_res, 1'b0};
  assign fin_entry  = {fin_res, IDX_W'(rows_seen_r), fin_edge_res, 1'b0};

  // A pending row 0 only exists at the start of a generation, so at most two
  // results go in per item: the held row, row k-1, or row k-1 plus the last row.
  always_comb begin
    push_a = in_fire && (held_valid_r || mid_v || final_row);
    push_b = in_fire && mid_v && final_row;
    if (held_valid_r) begin
      data_a = held_entry;
    end else if (mid_v) begin
      data_a = mid_entry;
    end else begin
      data_a = fin_entry;
    end
  end

  lrs_queue #(.DATA_W(DATA_W)) u_queue (
    .clk          (clk),
    .rst_n        (rst_n),
    .push_a       (push_a),
    .data_a       (data_a),
    .push_b       (push_b),
    .data_b       (fin_entry),
    .room_for_two (room_for_two),
    .head_valid   (out_valid),
    .head_data    (head_data),
    .pop          (out_ready)
  );

  assign out_next_row  = head_data[DATA_W-1 -: ROW_WIDTH];
  assign out_row_index = lrs_pkg::ROW_INDEX_W'(head_data[3 +: IDX_W]);
  assign out_right_out = head_data[2];
  assign out_left_out  = head_data[1];
  assign out_last      = head_data[0];

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_width_r <= lrs_pkg::ACTIVE_WIDTH_RST;
      row_count_r    <= lrs_pkg::ROW_COUNT_RST;
    end else if (cfg_we) begin
      unique case (lrs_pkg::cfg_reg_t'(cfg_index))
        lrs_pkg::REG_ACTIVE_WIDTH: active_width_r <= cfg_wdata[AW_W-1:0];
        lrs_pkg::REG_ROW_COUNT:    row_count_r    <= cfg_wdata[RC_W-1:0];
        default: ;
      endcase
    end
  end

  // Restart the row count after the final row, else advance it.
  assign rows_seen_nxt = final_row ? '0 : rows_seen_r + RC_W'(1);

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_seen_r  <= '0;
      held_valid_r <= 1'b0;
    end else if (in_fire) begin
      rows_seen_r  <= rows_seen_nxt;
      held_valid_r <= final_row;
    end
  end

  // Line buffers and the held row 0 result.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      older_row_r   <= middle_row_r;
      older_edge_r  <= middle_edge_r;
      middle_row_r  <= cur_row;
      middle_edge_r <= cur_edge;
      if (rows_seen_r == '0) begin
        first_row_r  <= cur_row;
        first_edge_r <= cur_edge;
      end
      if (rows_seen_r == RC_W'(1)) begin
        second_row_r  <= cur_row;
        second_edge_r <= cur_edge;
      end
      if (final_row) begin
        held_row_r  <= wrap_res;
        held_edge_r <= wrap_edge_res;
      end
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
                   held_valid_r |-> (rows_seen_r == '0))
    else $error("life_row_stepper: row 0 pending outside generation start");

  assert property (@(posedge clk) disable iff (!rst_n)
                   (in_fire && final_row) |=> held_valid_r)
    else $error("life_row_stepper: final row did not leave row 0 pending");

  assert property (@(posedge clk) disable iff (!rst_n)
                   (out_valid && out_last) |-> (out_row_index == '0))
    else $error("life_row_stepper: last result is not row 0");

  assert property (@(posedge clk) disable iff (!rst_n)
                   (in_fire && final_row) |-> mid_v)
    else $error("life_row_stepper: final row before two rows buffered");

endmodule

[tb/life_row_stepper_tb.sv]
// Self-checking testbench for life_row_stepper: directed strips, then random traffic.
// Depends on lrs_pkg and the life_row_stepper RTL; predicts every row result in place.
module life_row_stepper_tb;

  localparam int ROW_WIDTH   = 64;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SEGMENT_ROWS = 35;

  typedef struct packed {
    logic [ROW_WIDTH-1:0]            cells;
    logic [lrs_pkg::ROW_INDEX_W-1:0] index;
    logic                            left;
    logic                            right;
    logic                            last;
  } row_result_t;

  logic                            clk;
  logic                            rst_n = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  logic [ROW_WIDTH-1:0]            in_row_cells = '0;
  logic                            in_left_in = 1'b0;
  logic                            in_right_in = 1'b0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic [ROW_WIDTH-1:0]            out_next_row;
  logic [lrs_pkg::ROW_INDEX_W-1:0] out_row_index;
  logic                            out_left_out;
  logic                            out_right_out;
  logic                            out_last;
  logic                            cfg_we = 1'b0;
  logic [lrs_pkg::CFG_INDEX_W-1:0] cfg_index = lrs_pkg::REG_ACTIVE_WIDTH;
  logic [lrs_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;

  // Shadow of the block: configuration, line buffers, wrap rows and the held row 0.
  logic [lrs_pkg::ACTIVE_WIDTH_W-1:0] shadow_width;
  logic [lrs_pkg::ROW_COUNT_W-1:0]    shadow_rows;
  logic [ROW_WIDTH-1:0]      up_row, mid_row, top_row, top_next_row, wrap_row;
  lrs_pkg::edge_pair_t       up_edge, mid_edge, top_edge, top_next_edge, wrap_edge;
  logic [lrs_pkg::ROW_INDEX_W-1:0] rows_in_gen;
  bit                        wrap_pending;

  row_result_t next_rows[$];

  int idle_pct;
  int stall_pct;
  int cycle_count;
  int fail_count;
  int rows_sent;
  int results_checked;
  int wraps_checked;
  int config_writes;

  life_row_stepper #(
    .ROW_WIDTH      (ROW_WIDTH),
    .ROW_INDEX_BITS (lrs_pkg::ROW_INDEX_W)
  ) u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_row_cells  (in_row_cells),
    .in_left_in    (in_left_in),
    .in_right_in   (in_right_in),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_next_row  (out_next_row),
    .out_row_index (out_row_index),
    .out_left_out  (out_left_out),
    .out_right_out (out_right_out),
    .out_last      (out_last),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Cell of a row at any column; columns off either end read the edge bits.
  function automatic int cell_at(input logic [ROW_WIDTH-1:0] row,
                                 input lrs_pkg::edge_pair_t e,
                                 input int col, input int w);
    if (col < 0) return int'(e.left);
    if (col >= w) return int'(e.right);
    return int'(row[col]);
  endfunction

  // One Life generation of the middle row, B3/S23, plus its new edge cells.
  function automatic logic [ROW_WIDTH-1:0] next_gen(
    input logic [ROW_WIDTH-1:0] up, input lrs_pkg::edge_pair_t ue,
    input logic [ROW_WIDTH-1:0] mid, input lrs_pkg::edge_pair_t me,
    input logic [ROW_WIDTH-1:0] dn, input lrs_pkg::edge_pair_t de,
    input int w, output lrs_pkg::edge_pair_t eo);
    logic [ROW_WIDTH-1:0] res;
    int live;
    int alive;
    res = '0;
    for (int c = 0; c < w; c++) begin
      live = cell_at(up, ue, c - 1, w) + cell_at(up, ue, c, w) + cell_at(up, ue, c + 1, w) +
             cell_at(mid, me, c - 1, w) + cell_at(mid, me, c + 1, w) +
             cell_at(dn, de, c - 1, w) + cell_at(dn, de, c, w) + cell_at(dn, de, c + 1, w);
      alive = cell_at(mid, me, c, w);
      if (live == 3 || (alive != 0 && live == 2)) res[c] = 1'b1;
    end
    eo.left  = res[0];
    eo.right = res[w-1];
    return res;
  endfunction

  function automatic void clear_strip();
    shadow_width  = lrs_pkg::ACTIVE_WIDTH_RST;
    shadow_rows   = lrs_pkg::ROW_COUNT_RST;
    up_row        = '0;
    mid_row       = '0;
    top_row       = '0;
    top_next_row  = '0;
    wrap_row      = '0;
    up_edge       = '0;
    mid_edge      = '0;
    top_edge      = '0;
    top_next_edge = '0;
    wrap_edge     = '0;
    rows_in_gen   = '0;
    wrap_pending  = 1'b0;
    next_rows.delete();
  endfunction

  // Advance the shadow strip by one row and queue the results that row releases.
  function automatic void step_strip(input logic [ROW_WIDTH-1:0] cells, input logic l,
                                     input logic r);
    int w;
    int n;
    int k;
    bit final_row;
    logic [ROW_WIDTH-1:0] cur;
    logic [ROW_WIDTH-1:0] res;
    lrs_pkg::edge_pair_t ce;
    lrs_pkg::edge_pair_t eo;
    w = int'(shadow_width);
    if (w < 1) w = 1;
    if (w > ROW_WIDTH) w = ROW_WIDTH;
    n = (shadow_rows < lrs_pkg::MIN_ROW_COUNT) ? int'(lrs_pkg::MIN_ROW_COUNT) :
                                                 int'(shadow_rows);
    cur = (w >= ROW_WIDTH) ? cells : (cells & ((64'd1 << w) - 64'd1));
    ce.left  = l;
    ce.right = r;
    k = int'(rows_in_gen);
    final_row = (k + 1 >= n);

    // Row 0 of the previous generation goes out ahead of anything else.
    if (wrap_pending) begin
      next_rows.push_back('{wrap_row, '0, wrap_edge.left, wrap_edge.right, 1'b1});
      wrap_pending = 1'b0;
    end

    if (k == 0) begin
      top_row  = cur;
      top_edge = ce;
    end else if (k == 1) begin
      top_next_row  = cur;
      top_next_edge = ce;
    end else begin
      res = next_gen(up_row, up_edge, mid_row, mid_edge, cur, ce, w, eo);
      next_rows.push_back('{res, lrs_pkg::ROW_INDEX_W'(k - 1), eo.left, eo.right, 1'b0});
    end

    // The final row closes the wrap: it sees row 0 below, and row 0 sees it above.
    if (final_row) begin
      res = next_gen(mid_row, mid_edge, cur, ce, top_row, top_edge, w, eo);
      next_rows.push_back('{res, lrs_pkg::ROW_INDEX_W'(k), eo.left, eo.right, 1'b0});
      wrap_row = next_gen(cur, ce, top_row, top_edge, top_next_row, top_next_edge, w,
                          wrap_edge);
      wrap_pending = 1'b1;
    end

    up_row      = mid_row;
    up_edge     = mid_edge;
    mid_row     = cur;
    mid_edge    = ce;
    rows_in_gen = final_row ? '0 : lrs_pkg::ROW_INDEX_W'(k + 1);
  endfunction

  // Check results, predict accepted items and track register writes, all on the
  // values sampled at this edge.
  always @(posedge clk) begin
    row_result_t got;
    row_result_t exp_row;
    if (!rst_n) begin
      clear_strip();
    end else begin
      if (out_valid && out_ready) begin
        got = '{out_next_row, out_row_index, out_left_out, out_right_out, out_last};
        if (next_rows.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected row result: cells %h index %0d left %b right %b last %b",
                     got.cells, got.index, got.left, got.right, got.last);
        end else begin
          exp_row = next_rows.pop_front();
          results_checked++;
          if (exp_row.last) wraps_checked++;
          if (got.cells !== exp_row.cells || got.index !== exp_row.index ||
              got.left !== exp_row.left || got.right !== exp_row.right ||
              got.last !== exp_row.last) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("row result mismatch: expected cells %h index %0d l %b r %b last %b",
                       exp_row.cells, exp_row.index, exp_row.left, exp_row.right,
                       exp_row.last);
              $display("                     actual   cells %h index %0d l %b r %b last %b",
                       got.cells, got.index, got.left, got.right, got.last);
            end
          end
        end
      end
      if (in_valid && in_ready) begin
        step_strip(in_row_cells, in_left_in, in_right_in);
        rows_sent++;
      end
      if (cfg_we) begin
        if (cfg_index == lrs_pkg::REG_ACTIVE_WIDTH) begin
          shadow_width = cfg_wdata[lrs_pkg::ACTIVE_WIDTH_W-1:0];
        end else begin
          shadow_rows = cfg_wdata[lrs_pkg::ROW_COUNT_W-1:0];
        end
        config_writes++;
      end
    end
  end

  // Receiver: stall the result channel at the current rate.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Watchdog: end the run once cycle_count reaches CYCLE_LIMIT.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               next_rows.size());
      $display("life_row_stepper_tb NOT OK");
      $finish;
    end
  end

  // Offer one row; hold valid and payload until the block takes it. Valid stays
  // high on return so a back-to-back row does not toggle it within one step.
  task automatic send_row(input logic [ROW_WIDTH-1:0] cells, input logic l, input logic r);
    int gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct && gap < 60) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_row_cells <= cells;
    in_left_in   <= l;
    in_right_in  <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Drop valid and wait for every expected result, then let the pipe settle,
  // since rows 0 and 1 of a generation release nothing.
  task automatic drain_strip();
    in_valid <= 1'b0;
    @(posedge clk);
    while (next_rows.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write one register; call only with the block drained.
  task automatic write_reg(input lrs_pkg::cfg_reg_t idx,
                           input logic [lrs_pkg::CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [ROW_WIDTH-1:0] random_row();
    logic [ROW_WIDTH-1:0] a;
    logic [ROW_WIDTH-1:0] b;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    case ($urandom_range(3))
      0: return a & b;
      1: return a | b;
      2: return a & b & {$urandom, $urandom};
      default: return a;
    endcase
  endfunction

  // Defaults from reset, then cut the 64-row strip short mid-generation.
  task automatic test_default_strip();
    send_row('1, 1'b1, 1'b1);
    send_row('0, 1'b0, 1'b0);
    send_row({32{2'b01}}, 1'b1, 1'b0);
    send_row(64'h0000_0000_0000_0007, 1'b0, 1'b1);
    drain_strip();
    write_reg(lrs_pkg::REG_ROW_COUNT, lrs_pkg::MIN_ROW_COUNT);
    send_row(64'h8000_0000_0000_0003, 1'b1, 1'b1);
  endtask

  // Width 0 acts as 1 and row count 0 acts as 3.
  task automatic test_clamped_config();
    drain_strip();
    write_reg(lrs_pkg::REG_ACTIVE_WIDTH, 16'h0000);
    write_reg(lrs_pkg::REG_ROW_COUNT, 16'h0000);
    send_row(64'hFFFF_FFFF_FFFF_FFFE, 1'b1, 1'b1);
    send_row(64'h0000_0000_0000_0001, 1'b0, 1'b1);
    send_row('1, 1'b1, 1'b0);
  endtask

  // Width above 64 acts as 64; write data bits above the register are dropped.
  task automatic test_width_over_range();
    drain_strip();
    write_reg(lrs_pkg::REG_ACTIVE_WIDTH, 16'hFF7F);
    write_reg(lrs_pkg::REG_ROW_COUNT, 16'h0002);
    send_row(64'h8000_0000_0000_0002, 1'b0, 1'b1);
    send_row(64'hC000_0000_0000_0004, 1'b1, 1'b0);
    send_row(64'h8000_0000_0000_0007, 1'b1, 1'b1);
  endtask

  // Cells beyond a narrow width must be ignored; right edge sits next to column 4.
  task automatic test_bits_beyond_width();
    drain_strip();
    write_reg(lrs_pkg::REG_ACTIVE_WIDTH, 16'hAA05);
    write_reg(lrs_pkg::REG_ROW_COUNT, 16'h0004);
    send_row(64'hFFFF_FFFF_FFFF_FFE4, 1'b0, 1'b1);
    send_row(64'hAAAA_AAAA_AAAA_AA8E, 1'b1, 1'b1);
    send_row(64'h5555_5555_5555_5571, 1'b0, 1'b0);
    send_row(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0);
  endtask

  // Largest row count, then shrink it below the rows already seen.
  task automatic test_long_strip_cut_short();
    drain_strip();
    write_reg(lrs_pkg::REG_ACTIVE_WIDTH, 16'h0040);
    write_reg(lrs_pkg::REG_ROW_COUNT, 16'hFFFF);
    repeat (4) send_row(random_row(), 1'($urandom), 1'($urandom));
    drain_strip();
    write_reg(lrs_pkg::REG_ROW_COUNT, 16'h0001);
    send_row(random_row(), 1'b1, 1'b0);
  endtask

  // Random strips under random settings; now and then rewrite the row count mid-way.
  task automatic test_random_traffic(input int send_idle, input int recv_stall,
                                     input int segments);
    int w;
    int rows;
    drain_strip();
    idle_pct  = send_idle;
    stall_pct = recv_stall;
    repeat (segments) begin
      drain_strip();
      case ($urandom_range(9))
        0: w = 1;
        1: w = 2;
        2: w = ROW_WIDTH;
        3: w = 0;
        4: w = $urandom_range(65, 127);
        default: w = $urandom_range(3, 63);
      endcase
      case ($urandom_range(9))
        0: rows = $urandom_range(0, 2);
        1: rows = $urandom_range(20, 70);
        default: rows = $urandom_range(3, 9);
      endcase
      write_reg(lrs_pkg::REG_ACTIVE_WIDTH, {9'($urandom), 7'(w)});
      write_reg(lrs_pkg::REG_ROW_COUNT, 16'(rows));
      repeat (SEGMENT_ROWS) begin
        if ($urandom_range(39) == 0) begin
          drain_strip();
          write_reg(lrs_pkg::REG_ROW_COUNT, 16'($urandom_range(0, 6)));
        end
        send_row(random_row(), 1'($urandom), 1'($urandom));
      end
    end
  endtask

  initial begin
    idle_pct  = 0;
    stall_pct = 0;
    // Hold reset low from the start, then release.
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_strip();
    test_clamped_config();
    test_width_over_range();
    test_bits_beyond_width();
    test_long_strip_cut_short();

    test_random_traffic(0, 0, 6);
    test_random_traffic(75, 0, 6);
    test_random_traffic(0, 75, 6);
    test_random_traffic(21, 21, 6);

    // Wait out every outstanding result, then let the block sit quiet.
    drain_strip();
    repeat (8) @(posedge clk);

    $display("sent %0d rows over %0d register writes; checked %0d results, %0d wrapped rows",
             rows_sent, config_writes, results_checked, wraps_checked);
    if (fail_count == 0 && next_rows.size() == 0) begin
      $display("life_row_stepper_tb OK");
    end else begin
      $display("%0d failures, %0d results never arrived", fail_count, next_rows.size());
      $display("life_row_stepper_tb NOT OK");
    end
    $finish;
  end

endmodule
